// ===== design/egd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed widths for the order-2 exponential-Golomb decoder.
// Depends on nothing; every other design file imports it.
package egd_pkg;

  localparam int VALUE_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  // One decoded code word as produced by the bit decoder.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               code_error;
  } egd_result_t;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               code_error;
    logic               last_in_byte;
  } egd_entry_t;

endpackage

// ===== design/egd_bit_decoder.sv =====
`timescale 1ns / 1ps
// Bit-serial exponential-Golomb state machine: consumes one code bit per step.
// Depends on egd_pkg.
module egd_bit_decoder #(
  parameter int MAX_ZEROS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                code_bit,
  input  logic                clear,
  output logic                emit,
  output egd_pkg::egd_result_t result
);
  import egd_pkg::*;

  localparam int ZC_W   = $clog2(MAX_ZEROS + 1);
  localparam int LEFT_W = $clog2(MAX_ZEROS + 3);
  localparam int ACC_W  = MAX_ZEROS + 2;
  localparam int SUM_W  = (ACC_W + 1 > VALUE_W) ? ACC_W + 1 : VALUE_W;

  logic              in_suffix_r, in_suffix_nxt;
  logic [ZC_W-1:0]   zero_count_r, zero_count_nxt;
  logic [LEFT_W-1:0] bits_left_r, bits_left_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    logic              cur_suf;
    logic [ZC_W-1:0]   cur_zc;
    logic [LEFT_W-1:0] cur_left;
    logic [ACC_W-1:0]  cur_acc;
    logic [LEFT_W-1:0] left_dec;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum;

    // A restart clears the state before the first bit of its byte is used.
    cur_suf  = clear ? 1'b0 : in_suffix_r;
    cur_zc   = clear ? '0 : zero_count_r;
    cur_left = clear ? '0 : bits_left_r;
    cur_acc  = clear ? '0 : acc_r;
    left_dec = '0;
    base     = '0;
    sum      = '0;

    in_suffix_nxt  = in_suffix_r;
    zero_count_nxt = zero_count_r;
    bits_left_nxt  = bits_left_r;
    acc_nxt        = acc_r;
    emit           = 1'b0;
    result         = '0;

    if (step) begin
      in_suffix_nxt  = cur_suf;
      zero_count_nxt = cur_zc;
      bits_left_nxt  = cur_left;
      acc_nxt        = cur_acc;
      if (cur_suf) begin
        acc_nxt       = {cur_acc[ACC_W-2:0], code_bit};
        left_dec      = (cur_left != '0) ? cur_left - 1'b1 : '0;
        bits_left_nxt = left_dec;
        if (left_dec == '0) begin
          base  = (SUM_W'(1) << ({1'b0, cur_zc} + (ZC_W + 1)'(2))) - SUM_W'(4);
          sum   = base + SUM_W'(acc_nxt);
          emit  = 1'b1;
          result.value      = sum[VALUE_W-1:0];
          result.code_error = 1'b0;
          in_suffix_nxt  = 1'b0;
          zero_count_nxt = '0;
          bits_left_nxt  = '0;
          acc_nxt        = '0;
        end
      end else if (code_bit) begin
        in_suffix_nxt = 1'b1;
        bits_left_nxt = LEFT_W'(cur_zc) + LEFT_W'(2);
        acc_nxt       = '0;
      end else if (cur_zc >= ZC_W'(MAX_ZEROS)) begin
        // Prefix too long: report it and start searching again.
        emit              = 1'b1;
        result.value      = '0;
        result.code_error = 1'b1;
        zero_count_nxt    = '0;
      end else begin
        zero_count_nxt = cur_zc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_suffix_r  <= 1'b0;
      zero_count_r <= '0;
      bits_left_r  <= '0;
      acc_r        <= '0;
    end else begin
      in_suffix_r  <= in_suffix_nxt;
      zero_count_r <= zero_count_nxt;
      bits_left_r  <= bits_left_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

// ===== design/egd_result_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue holding result items for the output channel.
// Depends on egd_pkg.
module egd_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  egd_pkg::egd_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output egd_pkg::egd_entry_t head_entry
);
  import egd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  egd_entry_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/exp_golomb_order2_decoder_top.sv =====
`timescale 1ns / 1ps
// Order-2 exponential-Golomb decoder. Each accepted item is one compressed byte, whose bits
// are decoded most significant first, one bit per clock cycle while decoding is not paused,
// by a shift register feeding a small bit-serial state machine; the next byte is taken in
// the same cycle as the last bit of the current one, so bytes follow without gaps while the
// output side keeps up. Code words may span byte boundaries. Every completed code word, and
// every over-long prefix (reported with code_error set and a value of zero), yields one
// result item; up to three can come from one byte. The last result of a byte is only known
// once the byte's last bit has been seen, so each result waits in a one-entry holding
// register until either a further result arrives or the byte ends, and then moves into a
// four-entry output queue with last_in_byte settled. When that queue is full and a result
// is waiting, bit decoding pauses. Setting restart with a byte clears the decoder state
// before that byte's first bit is decoded.

module exp_golomb_order2_decoder_top #(
  parameter int MAX_PREFIX_ZEROS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic       out_code_error,
  output logic       out_last_in_byte
);
  import egd_pkg::*;

  localparam int BCNT_W = $clog2(BYTE_W + 1);

  // Byte shift register and the count of bits still to decode.
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [BCNT_W-1:0] bits_left_r, bits_left_nxt;
  logic              restart_r, restart_nxt;

  // Holding register for the most recent result of the byte in progress.
  logic        pend_v_r, pend_v_nxt;
  logic        pend_done_r, pend_done_nxt;
  egd_result_t pend_r, pend_nxt;

  logic        step;
  logic        last_bit;
  logic        in_accept;
  logic        emit;
  egd_result_t dec_result;
  logic        q_full;
  logic        q_push;
  egd_entry_t  q_push_entry;
  logic        q_valid;
  egd_entry_t  q_head;
  logic        q_pop;

  // A bit may be decoded unless a waiting result could not move on to the queue.
  assign step     = (bits_left_r != '0) && !(pend_v_r && q_full);
  assign last_bit = step && (bits_left_r == BCNT_W'(1));

  assign in_stall  = !((bits_left_r == '0) || last_bit);
  assign in_accept = in_valid && !in_stall;

  egd_bit_decoder #(
    .MAX_ZEROS (MAX_PREFIX_ZEROS)
  ) u_bit_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .code_bit (shift_r[BYTE_W-1]),
    .clear    (restart_r),
    .emit     (emit),
    .result   (dec_result)
  );

  // The held result leaves when a newer one arrives (so it was not the last of its byte)
  // or once its byte has ended (so it was).
  assign q_push = pend_v_r && (pend_done_r || emit) && !q_full;

  always_comb begin
    q_push_entry.value        = pend_r.value;
    q_push_entry.code_error   = pend_r.code_error;
    q_push_entry.last_in_byte = pend_done_r;
  end

  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    restart_nxt   = restart_r;
    if (in_accept) begin
      shift_nxt     = in_data_byte;
      bits_left_nxt = BCNT_W'(BYTE_W);
      restart_nxt   = in_restart;
    end else if (step) begin
      shift_nxt     = {shift_r[BYTE_W-2:0], 1'b0};
      bits_left_nxt = bits_left_r - 1'b1;
      restart_nxt   = 1'b0;
    end
  end

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_done_nxt = pend_done_r;
    pend_nxt      = pend_r;
    if (emit) begin
      pend_v_nxt    = 1'b1;
      pend_done_nxt = last_bit;
      pend_nxt      = dec_result;
    end else if (q_push) begin
      pend_v_nxt    = 1'b0;
      pend_done_nxt = 1'b0;
    end else if (last_bit && pend_v_r) begin
      pend_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    pend_r  <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r <= '0;
      restart_r   <= 1'b0;
      pend_v_r    <= 1'b0;
      pend_done_r <= 1'b0;
    end else begin
      bits_left_r <= bits_left_nxt;
      restart_r   <= restart_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_done_r <= pend_done_nxt;
    end
  end

  egd_result_queue u_result_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  assign q_pop            = q_valid && !out_stall;
  assign out_valid        = q_valid;
  assign out_value        = q_head.value;
  assign out_code_error   = q_head.code_error;
  assign out_last_in_byte = q_head.last_in_byte;

endmodule

// ===== tb/sv/exp_golomb_order2_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the order-2 exponential-Golomb decoder top level.
// Depends on egd_pkg for the result item type and on exp_golomb_order2_decoder_top.
module exp_golomb_order2_decoder_top_tb;
  import egd_pkg::*;

  localparam int MAX_ZEROS = 5;
  // The receiver's long hold-off starts once this many input items have gone in.
  localparam int HOLD_AT   = 300;
  // Items before which the sender waits until every expected result has come.
  localparam int DRAIN_A   = 19;
  localparam int DRAIN_B   = 260;
  localparam int RAND_ITEMS = 500;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_restart = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_value;
  logic       out_code_error;
  logic       out_last_in_byte;

  exp_golomb_order2_decoder_top #(
    .MAX_PREFIX_ZEROS(MAX_ZEROS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_code_error   (out_code_error),
    .out_last_in_byte (out_last_in_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One compressed byte waiting to be offered, with the idle gap that precedes it and a
  // flag that makes the sender wait for the output side to empty first.
  typedef struct {
    logic [7:0]  data;
    logic        restart;
    int unsigned gap;
    bit          drain;
  } byte_item_t;

  byte_item_t  pending_bytes[$];
  egd_entry_t  expected_codes[$];
  bit          stream_bits[$];

  // Cross-process counters are only ever updated with nonblocking assignments, so that
  // every process sees the values from before the current edge.
  int unsigned bytes_sent = 0;
  int unsigned results_expected = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mismatch_count = 0;

  // Decoder state as the predictor tracks it.
  bit          reading_suffix = 1'b0;
  logic [3:0]  pfx_zeros = '0;
  logic [3:0]  suffix_left = '0;
  logic [15:0] suffix_acc = '0;

  // Driver-private state.
  byte_item_t  next_byte;
  bit          next_loaded = 1'b0;
  int unsigned gap_left = 0;
  // Monitor-private state.
  int unsigned stall_left = 0;

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Decodes one byte, MSB first, against the tracked state and appends every code word
  // and over-long prefix it yields to the expected store. Returns how many were appended.
  function automatic int decode_byte(input logic [7:0] b, input logic fresh);
    egd_entry_t  found[$];
    egd_entry_t  e;
    logic [15:0] base;
    int          k;
    if (fresh) begin
      reading_suffix = 1'b0;
      pfx_zeros      = '0;
      suffix_left    = '0;
      suffix_acc     = '0;
    end
    for (k = 7; k >= 0; k--) begin
      e.last_in_byte = 1'b0;
      if (reading_suffix) begin
        suffix_acc = {suffix_acc[14:0], b[k]};
        if (suffix_left > 0) suffix_left--;
        if (suffix_left == 0) begin
          // Bases 0, 4, 12, 28, 60 and 124 follow from 2^(n+2) - 4.
          base = (16'd1 << (pfx_zeros + 4'd2)) - 16'd4;
          e.value      = 8'(base + suffix_acc);
          e.code_error = 1'b0;
          found = {found, e};
          reading_suffix = 1'b0;
          pfx_zeros      = '0;
          suffix_acc     = '0;
        end
      end else if (b[k]) begin
        reading_suffix = 1'b1;
        suffix_left    = pfx_zeros + 4'd2;
        suffix_acc     = '0;
      end else if (pfx_zeros >= MAX_ZEROS) begin
        // An over-long prefix is reported as an error item and the search starts afresh.
        e.value      = '0;
        e.code_error = 1'b1;
        found = {found, e};
        pfx_zeros = '0;
      end else begin
        pfx_zeros++;
      end
    end
    if (found.size() > 0) found[found.size()-1].last_in_byte = 1'b1;
    foreach (found[i]) expected_codes = {expected_codes, found[i]};
    return found.size();
  endfunction

  // Appends a byte to the pending items. Two windows of items go without any gap so that
  // the sender keeps pressing, one of them across the receiver's long hold-off.
  task automatic queue_byte(input logic [7:0] data, input logic restart);
    byte_item_t item;
    int         idx;
    idx = pending_bytes.size();
    item.data    = data;
    item.restart = restart;
    item.drain   = (idx == DRAIN_A) || (idx == DRAIN_B);
    if ((idx >= 150 && idx < 210) || (idx >= HOLD_AT && idx < HOLD_AT + 40)) item.gap = 0;
    else item.gap = pick_gap();
    pending_bytes = {pending_bytes, item};
  endtask

  // Driver: predicts each item as it is accepted and then presents the next one, after
  // its gap has run out. A stalled item is left exactly as it is.
  always @(posedge clk) begin : driver
    int n;
    bit fire;
    bit go;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'h00;
      in_restart   <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      go   = 1'b0;
      if (fire) begin
        n = decode_byte(in_data_byte, in_restart);
        results_expected <= results_expected + n;
        bytes_sent       <= bytes_sent + 1;
      end
      if (fire || !in_valid) begin
        if (!next_loaded && pending_bytes.size() > 0) begin
          next_byte   = pending_bytes.pop_front();
          next_loaded = 1'b1;
          gap_left    = next_byte.gap;
        end
        if (next_loaded) begin
          if (gap_left > 0) gap_left--;
          // A draining item waits for the edge after the last expected result has come.
          else if (next_byte.drain && (fire || results_seen != results_expected)) go = 1'b0;
          else go = 1'b1;
        end
        if (go) begin
          in_valid     <= 1'b1;
          in_data_byte <= next_byte.data;
          in_restart   <= next_byte.restart;
          next_loaded  = 1'b0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver's long hold-off, counted in cycles here and read by the monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_sent == HOLD_AT) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted result item against the oldest expectation and decides
  // whether the receiver stalls in the next cycle.
  always @(posedge clk) begin : monitor
    egd_entry_t want;
    bit         quiet;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (results_seen >= results_expected) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected result %0d: value %0d err %0b last %0b", results_seen,
                     out_value, out_code_error, out_last_in_byte);
        end else begin
          want = expected_codes.pop_front();
          if (out_value !== want.value || out_code_error !== want.code_error ||
              out_last_in_byte !== want.last_in_byte) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("result %0d: expected value %0d err %0b last %0b, got %0d %0b %0b",
                       results_seen, want.value, want.code_error, want.last_in_byte,
                       out_value, out_code_error, out_last_in_byte);
          end
        end
      end
      // Within a stretch of results no new random stall is started.
      quiet = (results_seen >= 200 && results_seen < 320);
      if (hold_left > 1) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int         r;
    int         n;
    int         k;
    logic [7:0] b;

    // Directed items. Restart starts a clean stream; a comment gives the decoding of most items.
    queue_byte(8'h80, 1'b1); // 1 00 gives zero, then five prefix zeros are left pending
    queue_byte(8'h00, 1'b0); // over-long prefix at once, then again after five more zeros
    queue_byte(8'h07, 1'b1); // five zeros and a one: the largest code begins
    queue_byte(8'hFF, 1'b0); // largest value 251, then 1 11 gives three
    queue_byte(8'h00, 1'b1); // one over-long prefix after a restart
    queue_byte(8'hFF, 1'b1); // two short codes and a partial one
    queue_byte(8'hFF, 1'b0); // three results from one byte
    queue_byte(8'h40, 1'b1); // n of one, base four
    queue_byte(8'h5F, 1'b1); // base four plus three, then a short code
    queue_byte(8'h27, 1'b1); // n of two, base twelve; a code begins at the last bit
    queue_byte(8'h3F, 1'b0); // code that straddles the byte boundary
    queue_byte(8'h1F, 1'b1); // n of three, base twenty-eight, suffix runs on
    queue_byte(8'hFF, 1'b0); // finishes at 59, then two short codes
    queue_byte(8'h0F, 1'b1); // n of four, base sixty
    queue_byte(8'hF0, 1'b0); // finishes at 123, then zero
    queue_byte(8'h01, 1'b0); // prefix count carried in runs over: error, then a code begins
    queue_byte(8'h00, 1'b1); // restart in the middle of a code word
    queue_byte(8'hAA, 1'b1);
    queue_byte(8'h55, 1'b1);
    queue_byte(8'h00, 1'b0); // the sender waits for the output side to empty first
    queue_byte(8'h00, 1'b0); // prefix zeros carried in run over the limit once more
    queue_byte(8'hFE, 1'b1);

    // Random part: mostly a well-formed bit stream of random code words, cut into bytes,
    // with some noise, some over-long prefixes and the odd restart.
    while (pending_bytes.size() < 22 + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        for (k = 0; k < 8; k++) stream_bits = {stream_bits, 1'($urandom_range(0, 1))};
      end else if (r < 13) begin
        n = $urandom_range(MAX_ZEROS + 1, MAX_ZEROS + 3);
        for (k = 0; k < n; k++) stream_bits = {stream_bits, 1'b0};
      end else begin
        n = $urandom_range(0, MAX_ZEROS);
        for (k = 0; k < n; k++) stream_bits = {stream_bits, 1'b0};
        stream_bits = {stream_bits, 1'b1};
        for (k = 0; k < n + 2; k++) stream_bits = {stream_bits, 1'($urandom_range(0, 1))};
      end
      while (stream_bits.size() >= 8) begin
        b = '0;
        for (k = 0; k < 8; k++) b = {b[6:0], stream_bits.pop_front()};
        queue_byte(b, $urandom_range(0, 39) == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item has gone in and every expected result has come out, then
    // allow a little longer so that any stray result is seen.
    do @(posedge clk);
    while (pending_bytes.size() != 0 || next_loaded || in_valid ||
           results_seen != results_expected);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net against a hung handshake; far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
